@@ design/oxi_pkg.sv @@
// oxi_pkg: shared types and constants of the pulse oximeter beat/spo2 monitor
// field widths, item and result layouts, command codes, register indexes
// no dependencies
package oxi_pkg;

    localparam int KIND_W     = 2;
    localparam int LEVEL_W    = 24;
    localparam int NOW_W      = 32;
    localparam int BEATS_W    = 16;
    localparam int SPO2_W     = 7;
    localparam int CODE_W     = 2;
    localparam int DIVIDEND_W = LEVEL_W + 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 5;
    localparam int EST_STEPS  = DIVIDEND_W;
    localparam int MEAN_STEPS = SPO2_W;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    localparam logic [SPO2_W-1:0] SPO2_BASE = 7'd110;

    localparam logic [KIND_W-1:0] KIND_SAMPLE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FAIL      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECONNECT = 2'd2;

    localparam logic [CODE_W-1:0] BPM_NONE       = 2'd0;
    localparam logic [CODE_W-1:0] BPM_ABNORMAL   = 2'd1;
    localparam logic [CODE_W-1:0] BPM_NORMALIZED = 2'd2;

    localparam logic [CODE_W-1:0] LINK_NONE        = 2'd0;
    localparam logic [CODE_W-1:0] LINK_LOST        = 2'd1;
    localparam logic [CODE_W-1:0] LINK_RECONNECTED = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_RISE_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_MS      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BPM_LOW        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BPM_HIGH       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLDOFF_MS     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_NO_BEAT_MS     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPO2_FLOOR     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPO2_CEILING   = 3'd7;

    localparam logic [LEVEL_W-1:0] RST_RISE_THRESHOLD = 24'd1000;
    localparam logic [31:0]        RST_WINDOW_MS      = 32'd60000;
    localparam logic [15:0]        RST_BPM_LOW        = 16'd50;
    localparam logic [15:0]        RST_BPM_HIGH       = 16'd100;
    localparam logic [31:0]        RST_HOLDOFF_MS     = 32'd5000;
    localparam logic [31:0]        RST_NO_BEAT_MS     = 32'd10000;
    localparam logic [SPO2_W-1:0]  RST_SPO2_FLOOR     = 7'd70;
    localparam logic [SPO2_W-1:0]  RST_SPO2_CEILING   = 7'd100;

    typedef enum logic [1:0] {
        OP_SKIP      = 2'd0,
        OP_FAIL      = 2'd1,
        OP_RECONNECT = 2'd2,
        OP_SAMPLE    = 2'd3
    } t_op;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LEVEL_W-1:0] ir_level;
        logic [LEVEL_W-1:0] red_level;
        logic [NOW_W-1:0]   now_ms;
        logic               emergency;
    } t_item;

    typedef struct packed {
        logic                report_valid;
        logic [BEATS_W-1:0]  beats_in_window;
        logic [SPO2_W-1:0]   spo2_mean;
        logic [CODE_W-1:0]   bpm_alert;
        logic                no_beat_alert;
        logic [CODE_W-1:0]   link_event;
    } t_result;

    typedef struct packed {
        t_op                   op;
        logic [LEVEL_W-1:0]    ir_level;
        logic [DIVIDEND_W-1:0] dividend;
        logic [NOW_W-1:0]      now_ms;
    } t_cmd;

endpackage

@@ design/oxi_item_if.sv @@
// oxi_item_if: input request channel, valid/ready with one t_item payload
// depends on oxi_pkg
interface oxi_item_if;
    logic           valid;
    logic           ready;
    oxi_pkg::t_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/oxi_result_if.sv @@
// oxi_result_if: result request channel, valid/ready with one t_result payload
// depends on oxi_pkg
interface oxi_result_if;
    logic             valid;
    logic             ready;
    oxi_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/oxi_front.sv @@
// oxi_front: accepts input requests, classifies them and forms the 25*red dividend
// depends on oxi_pkg and oxi_item_if
module oxi_front (
    oxi_item_if.sink        i_item,
    input  logic            i_full,
    output logic            o_push,
    output oxi_pkg::t_cmd   o_cmd
);

    oxi_pkg::t_op                   op;
    logic [oxi_pkg::DIVIDEND_W-1:0] red_x;

    always_comb begin
        if (i_item.data.emergency) begin
            op = oxi_pkg::OP_SKIP;
        end else begin
            case (i_item.data.kind)
                oxi_pkg::KIND_SAMPLE:    op = oxi_pkg::OP_SAMPLE;
                oxi_pkg::KIND_FAIL:      op = oxi_pkg::OP_FAIL;
                oxi_pkg::KIND_RECONNECT: op = oxi_pkg::OP_RECONNECT;
                default:                 op = oxi_pkg::OP_SKIP;
            endcase
        end
    end

    assign red_x = oxi_pkg::DIVIDEND_W'(i_item.data.red_level);

    assign o_cmd.op       = op;
    assign o_cmd.ir_level = i_item.data.ir_level;
    assign o_cmd.dividend = (red_x << 4) + (red_x << 3) + red_x;
    assign o_cmd.now_ms   = i_item.data.now_ms;

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

endmodule

@@ design/oxi_fifo.sv @@
// oxi_fifo: short command queue between the front and the execution unit
// depends on oxi_pkg
module oxi_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  oxi_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output oxi_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    oxi_pkg::t_cmd                  r_mem [oxi_pkg::FIFO_DEPTH];
    logic [oxi_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [oxi_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [oxi_pkg::FIFO_CNT_W-1:0] r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = r_count == oxi_pkg::FIFO_CNT_W'(oxi_pkg::FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/oxi_exec.sv @@
// oxi_exec: execution unit, config registers, beat and window state,
// serial spo2 ratio divider, serial mean divider and the result register
// depends on oxi_pkg and oxi_result_if
module oxi_exec #(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [oxi_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [oxi_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_cmd_valid,
    input  oxi_pkg::t_cmd                    i_cmd,
    output logic                             o_cmd_pop,
    oxi_result_if.source                     o_result
);

    localparam int SUM_BITS  = COUNT_BITS + oxi_pkg::SPO2_W;
    localparam int CMP_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int BEAT_BITS = (COUNT_BITS > oxi_pkg::BEATS_W) ? COUNT_BITS : oxi_pkg::BEATS_W;
    localparam int LW        = oxi_pkg::LEVEL_W;
    localparam int DW        = oxi_pkg::DIVIDEND_W;
    localparam int SW        = oxi_pkg::SPO2_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RUN  = 7'b0000010,
        S_EST  = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_WIN  = 7'b0010000,
        S_MEAN = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;

    logic [LW-1:0] r_rise_thr;
    logic [31:0]   r_window;
    logic [15:0]   r_bpm_low;
    logic [15:0]   r_bpm_high;
    logic [31:0]   r_holdoff;
    logic [31:0]   r_no_beat;
    logic [SW-1:0] r_floor;
    logic [SW-1:0] r_ceil;

    logic [LW-1:0]         r_prev_ir;
    logic                  r_rising;
    logic [COUNT_BITS-1:0] r_beats;
    logic [SUM_BITS-1:0]   r_sum;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [TIME_BITS-1:0]  r_win_start;
    logic [TIME_BITS-1:0]  r_last_beat;
    logic [TIME_BITS-1:0]  r_last_bpm;
    logic [TIME_BITS-1:0]  r_last_nb;
    logic                  r_abnormal;
    logic                  r_connected;

    oxi_pkg::t_cmd                r_cmd;
    oxi_pkg::t_result             r_res;
    logic [LW-1:0]                r_rem;
    logic [DW-1:0]                r_quo;
    logic [oxi_pkg::STEP_W-1:0]   r_step;
    logic [SUM_BITS-1:0]          r_msum;
    logic [SUM_BITS-1:0]          r_mdiv;
    logic [SW-1:0]                r_mq;
    logic                         r_out_valid;
    oxi_pkg::t_result             r_out;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] el_win;
    logic [TIME_BITS-1:0] el_beat;
    logic [TIME_BITS-1:0] el_bpm;
    logic [TIME_BITS-1:0] el_nb;
    logic                 win_due;
    logic                 bpm_oor;
    logic                 bpm_hold_ok;
    logic                 nb_due;
    logic [BEAT_BITS-1:0] beats_x;
    logic [oxi_pkg::BEATS_W-1:0] beats_sat;
    logic                 beat_hit;
    logic [LW:0]          est_trial;
    logic                 est_ge;
    logic                 est_neg;
    logic [SW-1:0]        est_raw;
    logic [SW-1:0]        est_ceil;
    logic [SW-1:0]        est_val;
    logic                 mean_ge;
    logic                 out_free;

    assign now_t   = TIME_BITS'(r_cmd.now_ms);
    assign el_win  = now_t - r_win_start;
    assign el_beat = now_t - r_last_beat;
    assign el_bpm  = now_t - r_last_bpm;
    assign el_nb   = now_t - r_last_nb;

    assign win_due     = CMP_BITS'(el_win) >= CMP_BITS'(r_window);
    assign bpm_hold_ok = CMP_BITS'(el_bpm) >= CMP_BITS'(r_holdoff);
    assign nb_due      = (CMP_BITS'(el_beat) >= CMP_BITS'(r_no_beat))
                      && (CMP_BITS'(el_nb) >= CMP_BITS'(r_holdoff));

    assign beats_x   = BEAT_BITS'(r_beats);
    assign bpm_oor   = (beats_x < BEAT_BITS'(r_bpm_low)) || (beats_x > BEAT_BITS'(r_bpm_high));
    assign beats_sat = (beats_x > BEAT_BITS'({oxi_pkg::BEATS_W{1'b1}}))
                     ? {oxi_pkg::BEATS_W{1'b1}} : beats_x[oxi_pkg::BEATS_W-1:0];

    assign beat_hit = !r_rising && (r_cmd.ir_level > r_prev_ir)
                   && ((r_cmd.ir_level - r_prev_ir) > r_rise_thr);

    assign est_trial = {r_rem, r_quo[DW-1]};
    assign est_ge    = est_trial >= {1'b0, r_cmd.ir_level};

    // quotient above the base makes the estimate negative, the floor then wins
    assign est_neg  = r_quo > DW'(oxi_pkg::SPO2_BASE);
    assign est_raw  = oxi_pkg::SPO2_BASE - r_quo[SW-1:0];
    assign est_ceil = (est_raw > r_ceil) ? r_ceil : est_raw;
    assign est_val  = (est_neg || (est_ceil < r_floor)) ? r_floor : est_ceil;

    assign mean_ge = r_msum >= r_mdiv;

    assign out_free  = !r_out_valid || o_result.ready;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rise_thr  <= oxi_pkg::RST_RISE_THRESHOLD;
            r_window    <= oxi_pkg::RST_WINDOW_MS;
            r_bpm_low   <= oxi_pkg::RST_BPM_LOW;
            r_bpm_high  <= oxi_pkg::RST_BPM_HIGH;
            r_holdoff   <= oxi_pkg::RST_HOLDOFF_MS;
            r_no_beat   <= oxi_pkg::RST_NO_BEAT_MS;
            r_floor     <= oxi_pkg::RST_SPO2_FLOOR;
            r_ceil      <= oxi_pkg::RST_SPO2_CEILING;
            r_prev_ir   <= '0;
            r_rising    <= 1'b0;
            r_beats     <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_win_start <= '0;
            r_last_beat <= '0;
            r_last_bpm  <= '0;
            r_last_nb   <= '0;
            r_abnormal  <= 1'b0;
            r_connected <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    oxi_pkg::REG_RISE_THRESHOLD: r_rise_thr <= i_cfg_wdata[LW-1:0];
                    oxi_pkg::REG_WINDOW_MS:      r_window   <= i_cfg_wdata;
                    oxi_pkg::REG_BPM_LOW:        r_bpm_low  <= i_cfg_wdata[15:0];
                    oxi_pkg::REG_BPM_HIGH:       r_bpm_high <= i_cfg_wdata[15:0];
                    oxi_pkg::REG_HOLDOFF_MS:     r_holdoff  <= i_cfg_wdata;
                    oxi_pkg::REG_NO_BEAT_MS:     r_no_beat  <= i_cfg_wdata;
                    oxi_pkg::REG_SPO2_FLOOR:     r_floor    <= i_cfg_wdata[SW-1:0];
                    oxi_pkg::REG_SPO2_CEILING:   r_ceil     <= i_cfg_wdata[SW-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_res   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    case (r_cmd.op)
                        oxi_pkg::OP_FAIL: begin
                            if (r_connected) begin
                                r_res.link_event <= oxi_pkg::LINK_LOST;
                            end
                            r_connected <= 1'b0;
                            r_state     <= S_OUT;
                        end
                        oxi_pkg::OP_RECONNECT: begin
                            r_connected      <= 1'b1;
                            r_last_beat      <= now_t;
                            r_win_start      <= now_t;
                            r_beats          <= '0;
                            r_sum            <= '0;
                            r_cnt            <= '0;
                            r_res.link_event <= oxi_pkg::LINK_RECONNECTED;
                            r_state          <= S_OUT;
                        end
                        oxi_pkg::OP_SAMPLE: begin
                            if (r_connected) begin
                                if (beat_hit) begin
                                    if (!(&r_beats)) begin
                                        r_beats <= r_beats + 1'b1;
                                    end
                                    r_rising    <= 1'b1;
                                    r_last_beat <= now_t;
                                end else if (r_cmd.ir_level < r_prev_ir) begin
                                    r_rising <= 1'b0;
                                end
                                r_prev_ir <= r_cmd.ir_level;
                                if ((r_cmd.ir_level != '0) && !(&r_cnt)) begin
                                    r_rem   <= '0;
                                    r_quo   <= r_cmd.dividend;
                                    r_step  <= oxi_pkg::STEP_W'(oxi_pkg::EST_STEPS - 1);
                                    r_state <= S_EST;
                                end else begin
                                    r_state <= S_WIN;
                                end
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_EST: begin
                    r_rem <= est_ge ? LW'(est_trial - {1'b0, r_cmd.ir_level})
                                    : LW'(est_trial);
                    r_quo <= {r_quo[DW-2:0], est_ge};
                    if (r_step == '0) begin
                        r_state <= S_ACC;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_ACC: begin
                    r_sum   <= r_sum + SUM_BITS'(est_val);
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_WIN;
                end
                S_WIN: begin
                    if (win_due) begin
                        r_res.report_valid    <= 1'b1;
                        r_res.beats_in_window <= beats_sat;
                        if (bpm_oor) begin
                            if (!r_abnormal && bpm_hold_ok) begin
                                r_res.bpm_alert <= oxi_pkg::BPM_ABNORMAL;
                                r_abnormal      <= 1'b1;
                                r_last_bpm      <= now_t;
                            end
                        end else begin
                            if (r_abnormal) begin
                                r_res.bpm_alert <= oxi_pkg::BPM_NORMALIZED;
                            end
                            r_abnormal <= 1'b0;
                        end
                        if (nb_due) begin
                            r_res.no_beat_alert <= 1'b1;
                            r_last_nb           <= now_t;
                        end
                        r_msum      <= r_sum;
                        r_mdiv      <= SUM_BITS'(r_cnt) << (oxi_pkg::MEAN_STEPS - 1);
                        r_step      <= oxi_pkg::STEP_W'(oxi_pkg::MEAN_STEPS - 1);
                        r_beats     <= '0;
                        r_sum       <= '0;
                        r_cnt       <= '0;
                        r_win_start <= now_t;
                        if (r_cnt != '0) begin
                            r_state <= S_MEAN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MEAN: begin
                    if (mean_ge) begin
                        r_msum <= r_msum - r_mdiv;
                    end
                    r_mdiv <= r_mdiv >> 1;
                    r_mq   <= {r_mq[SW-2:0], mean_ge};
                    if (r_step == '0) begin
                        r_res.spo2_mean <= {r_mq[SW-2:0], mean_ge};
                        r_state         <= S_OUT;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ design/pulse_oximeter_beat_spo2_monitor_core.sv @@
// pulse_oximeter_beat_spo2_monitor_core: top level of the beat and spo2 window monitor
// front classifier, command queue and execution unit; depends on oxi_pkg,
// oxi_item_if, oxi_result_if, oxi_front, oxi_fifo, oxi_exec
//
//   channel   dir  handshake        payload
//   i_item    in   valid / ready    oxi_pkg::t_item (kind, levels, now_ms, emergency)
//   o_result  out  valid / ready    oxi_pkg::t_result (one per input request)
//   i_cfg_*   in   write enable     register index 0..7, 32-bit data
//
// a sample with nonzero ir passes accept, dispatch, the serial spo2 ratio divider,
// accumulate, window check and output; when a window closes with samples it also
// passes the serial mean divider before output; a zero-ir sample skips the ratio divider
// other requests go from dispatch to output; the execution unit handles one request at a time
// a two-entry queue lets the input take requests while a result waits in the output register
// synchronous active-low reset restores register defaults and all window state
module pulse_oximeter_beat_spo2_monitor_core #(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    oxi_item_if.sink                       i_item,
    oxi_result_if.source                   o_result,
    input  logic                           i_cfg_we,
    input  logic [oxi_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [oxi_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    logic          fifo_full;
    logic          push;
    oxi_pkg::t_cmd push_cmd;
    logic          cmd_valid;
    oxi_pkg::t_cmd cmd;
    logic          cmd_pop;

    oxi_front u_front (
        .i_item (i_item),
        .i_full (fifo_full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    oxi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (fifo_full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd),
        .i_pop   (cmd_pop)
    );

    oxi_exec #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result)
    );

endmodule
